/* design/keyframe_trs_interpolator_macros.svh */
// Assertion macros for the keyframe TRS interpolator checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef KEYFRAME_TRS_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_TRS_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled in reset
`define KTI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define KTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/kti_pkg.sv */
// Package for the keyframe TRS interpolator: sizes, codes, transaction types.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package kti_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int IDX_W     = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int MEM_DEPTH = 3 * MAX_KEYS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int ENTRY_W   = 128;
  localparam int Q_W       = 31;   // quaternion working component
  localparam int QN_W      = 30;   // normalised Q1.28 component
  localparam int RM_W      = 21;   // rotation matrix entry, Q5.16

  localparam logic [31:0]            ONE_Q16 = 32'h0001_0000;
  localparam logic signed [QN_W-1:0] QONE    = 30'sh1000_0000;
  localparam logic [5:0]             U_STEPS = 6'd16;
  localparam logic [5:0]             N_STEPS = 6'd29;

  // Command codes
  localparam logic [2:0] CMD_ADD_POS = 3'd0;
  localparam logic [2:0] CMD_ADD_ROT = 3'd1;
  localparam logic [2:0] CMD_ADD_SCL = 3'd2;
  localparam logic [2:0] CMD_CLEAR   = 3'd3;
  localparam logic [2:0] CMD_EVAL    = 3'd4;

  // Track codes
  localparam logic [1:0] TRK_POS = 2'd0;
  localparam logic [1:0] TRK_ROT = 2'd1;
  localparam logic [1:0] TRK_SCL = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_ACK, S_TRK, S_SCAN, S_HOLD, S_SEGA, S_UDIV, S_UGO,
    S_LMUL, S_LADD, S_RA, S_RB, S_RBD, S_DOTM, S_DOTA, S_FLIP,
    S_MID, S_MIDD, S_RFIN, S_QSET, S_NSQM, S_NSQA, S_NROOT, S_NDIVS,
    S_NDIVW, S_NEXT, S_MPM, S_MPA, S_MR, S_MEM, S_MEA, S_OUT
  } kti_state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        time_value;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
    logic signed [15:0] value_w;
  } kti_in_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic [1:0]         status;
    logic               last;
  } kti_out_t;

endpackage

/* design/keyframe_trs_interpolator.sv */
// Keyframe TRS interpolator top level: key store, track search, lerp/slerp, matrix.
// Depends on kti_pkg.
//
// Add and clear commands give one result in the cycle after acceptance and
// keep busy high for that one cycle. An evaluate gives four rows on
// consecutive cycles at its end. Its run time is dominated by the bit-serial
// quaternion normaliser (sum of squares, 32-step square root, four 29-step
// divisions), which a slerp runs nineteen times. All keys live in one
// synchronous memory read one entry per cycle. Results cannot be held off:
// each row is on out_item for exactly the cycle in which out_strobe is high.
`timescale 1ns / 1ps

module keyframe_trs_interpolator
  import kti_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  kti_in_t  in_item,
  output logic     out_strobe,
  output kti_out_t out_item
);

  kti_state_t state_r, state_nxt, ret_r;

  logic [CNT_W-1:0]   cnt_r [3];
  logic [ENTRY_W-1:0] key_mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] rd_r, a_r, b_r, wr_data;
  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;

  logic [1:0]       trk_r, stat_r, row_r;
  logic [IDX_W-1:0] j_r;
  logic [31:0]      t_r;
  logic [15:0]      u_r;
  logic [3:0]       k_r, bit_r;

  logic signed [31:0]     p_r [3];
  logic signed [31:0]     s_r [3];
  logic signed [Q_W-1:0]  qin_r [4];
  logic signed [QN_W-1:0] nq_r [4];
  logic signed [QN_W-1:0] qa_r [4];
  logic signed [QN_W-1:0] qb_r [4];
  logic signed [QN_W-1:0] q_r [4];

  logic [63:0]        n2_r, rx_r, rr_r, rbit_r;
  logic signed [63:0] dot_r;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_r;

  logic signed [59:0]     pp_r [9];
  logic signed [RM_W-1:0] rm_r [9];
  logic signed [31:0]     m_r [9];

  // Serial divider
  logic        div_go;
  logic [31:0] div_den, div_rem0, div_rem_r, div_den_r;
  logic [63:0] div_dq0, div_dq_r;
  logic [5:0]  div_steps, div_cnt_r;
  logic [32:0] div_rem2;

  // Derived values
  logic [CNT_W-1:0]      cur_n;
  logic [31:0]           rd_time;
  logic                  scan_hit, scan_end;
  logic signed [Q_W-1:0] qin_cur, qin_mag;
  logic signed [65:0]    prod_sh, elem_full;
  logic signed [31:0]    lerp_val;
  logic [64:0]           root_try;
  logic [1:0]            cmd_trk;

  function automatic logic [ADDR_W-1:0] key_addr(input logic [1:0] trk,
                                                 input logic [IDX_W-1:0] idx);
    key_addr = ADDR_W'(trk) * ADDR_W'(MAX_KEYS) + ADDR_W'(idx);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767)       sat16 = 16'h7FFF;
    else if (v < -32'sd32768) sat16 = 16'h8000;
    else                      sat16 = v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) sat32 = 32'sh8000_0000;
    else                           sat32 = v[31:0];
  endfunction

  function automatic logic signed [31:0] vcomp(input logic [ENTRY_W-1:0] e,
                                               input logic [1:0] k);
    case (k)
      2'd0:    vcomp = $signed(e[95:64]);
      2'd1:    vcomp = $signed(e[63:32]);
      default: vcomp = $signed(e[31:0]);
    endcase
  endfunction

  function automatic logic signed [Q_W-1:0] qcomp(input logic [ENTRY_W-1:0] e,
                                                  input logic [1:0] k);
    case (k)
      2'd0:    qcomp = Q_W'($signed(e[15:0]));
      2'd1:    qcomp = Q_W'($signed(e[31:16]));
      2'd2:    qcomp = Q_W'($signed(e[47:32]));
      default: qcomp = Q_W'($signed(e[63:48]));
    endcase
  endfunction

  function automatic logic [1:0] col_of(input logic [3:0] k);
    case (k)
      4'd0, 4'd3, 4'd6: col_of = 2'd0;
      4'd1, 4'd4, 4'd7: col_of = 2'd1;
      default:          col_of = 2'd2;
    endcase
  endfunction

  function automatic logic signed [RM_W-1:0] rq(input logic signed [61:0] v);
    logic signed [61:0] t;
    t  = (v + 62'sh80_0000_0000) >>> 40;
    rq = t[RM_W-1:0];
  endfunction

  // Derived values from stored state
  assign cur_n    = cnt_r[trk_r];
  assign rd_time  = rd_r[127:96];
  assign scan_hit = t_r < rd_time;
  assign scan_end = CNT_W'(j_r) == cur_n - CNT_W'(1);
  assign qin_cur  = qin_r[k_r[1:0]];
  assign qin_mag  = qin_cur[Q_W-1] ? -qin_cur : qin_cur;
  assign prod_sh  = prod_r >>> 16;
  assign lerp_val = vcomp(a_r, k_r[1:0]) + prod_sh[31:0];
  assign elem_full = (prod_r + 66'sd32768) >>> 16;
  assign root_try = {1'b0, rr_r} + {1'b0, rbit_r};
  assign div_rem2 = {div_rem_r, div_dq_r[63]};
  assign cmd_trk  = in_item.command[1:0];

  // Key write on an accepted add
  assign wr_en   = (state_r == S_IDLE) && start && (in_item.command <= CMD_ADD_SCL)
                   && (cnt_r[cmd_trk] != CNT_W'(MAX_KEYS));
  assign wr_addr = key_addr(cmd_trk, cnt_r[cmd_trk][IDX_W-1:0]);
  assign wr_data = (in_item.command == CMD_ADD_ROT)
                 ? {in_item.time_value, 32'd0, in_item.value_w, sat16(in_item.value_z),
                    sat16(in_item.value_y), sat16(in_item.value_x)}
                 : {in_item.time_value, in_item.value_x, in_item.value_y, in_item.value_z};

  // Key memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) key_mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= key_mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_item.command <= CMD_CLEAR)     state_nxt = S_ACK;
          else if (in_item.command == CMD_EVAL) state_nxt = S_TRK;
        end
      end
      S_ACK: state_nxt = S_IDLE;
      S_TRK: begin
        if (cur_n == '0)                 state_nxt = S_NEXT;
        else if (cur_n == CNT_W'(1))     state_nxt = S_HOLD;
        else                             state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_hit)      state_nxt = S_SEGA;
        else if (scan_end) state_nxt = S_HOLD;
      end
      S_HOLD:  state_nxt = (trk_r == TRK_ROT) ? S_NSQM : S_NEXT;
      S_SEGA:  state_nxt = (t_r > rd_time) ? S_UDIV : S_UGO;
      S_UDIV:  if (div_cnt_r == '0) state_nxt = S_UGO;
      S_UGO:   state_nxt = (trk_r == TRK_ROT) ? S_RA : S_LMUL;
      S_LMUL:  state_nxt = S_LADD;
      S_LADD:  state_nxt = (k_r == 4'd2) ? S_NEXT : S_LMUL;
      S_RA:    state_nxt = S_NSQM;
      S_RB:    state_nxt = S_NSQM;
      S_RBD:   state_nxt = S_DOTM;
      S_DOTM:  state_nxt = S_DOTA;
      S_DOTA:  state_nxt = (k_r == 4'd3) ? S_FLIP : S_DOTM;
      S_FLIP:  state_nxt = S_MID;
      S_MID:   state_nxt = S_NSQM;
      S_MIDD:  state_nxt = (bit_r == 4'd0) ? S_RFIN : S_MID;
      S_RFIN:  state_nxt = S_NSQM;
      S_QSET:  state_nxt = S_NEXT;
      S_NSQM:  state_nxt = S_NSQA;
      S_NSQA:  state_nxt = (k_r == 4'd3) ? S_NROOT : S_NSQM;
      S_NROOT: if (rbit_r == 64'd1) state_nxt = S_NDIVS;
      S_NDIVS: state_nxt = (k_r == 4'd0 && rr_r == 64'd0) ? ret_r : S_NDIVW;
      S_NDIVW: begin
        if (div_cnt_r == '0) state_nxt = (k_r == 4'd3) ? ret_r : S_NDIVS;
      end
      S_NEXT:  state_nxt = (trk_r == TRK_SCL) ? S_MPM : S_TRK;
      S_MPM:   state_nxt = S_MPA;
      S_MPA:   state_nxt = (k_r == 4'd8) ? S_MR : S_MPM;
      S_MR:    state_nxt = S_MEM;
      S_MEM:   state_nxt = S_MEA;
      S_MEA:   state_nxt = (k_r == 4'd8) ? S_OUT : S_MEM;
      S_OUT:   if (row_r == 2'd3) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs: memory reads, divider launch, multiplier operands
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = key_addr(trk_r, j_r);
    div_go    = 1'b0;
    div_den   = rd_r[127:96];
    div_rem0  = 32'd0;
    div_dq0   = 64'd0;
    div_steps = U_STEPS;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      S_TRK: begin
        rd_en   = 1'b1;
        rd_addr = key_addr(trk_r, (cur_n == CNT_W'(1)) ? IDX_W'(0) : IDX_W'(1));
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (scan_hit)      rd_addr = key_addr(trk_r, j_r - IDX_W'(1));
        else if (scan_end) rd_addr = key_addr(trk_r, j_r);
        else               rd_addr = key_addr(trk_r, j_r + IDX_W'(1));
      end
      S_SEGA: begin
        div_go    = t_r > rd_time;
        div_den   = b_r[127:96] - rd_time;
        div_rem0  = t_r - rd_time;
        div_steps = U_STEPS;
      end
      S_NDIVS: begin
        div_go    = !(k_r == 4'd0 && rr_r == 64'd0);
        div_den   = rr_r[31:0];
        div_rem0  = 32'(qin_mag[29:1]);
        div_dq0   = {qin_mag[0], 63'd0};
        div_steps = N_STEPS;
      end
      S_LMUL: begin
        mul_a = 33'(vcomp(b_r, k_r[1:0])) - 33'(vcomp(a_r, k_r[1:0]));
        mul_b = $signed({17'd0, u_r});
      end
      S_NSQM: begin
        mul_a = 33'(qin_cur);
        mul_b = 33'(qin_cur);
      end
      S_DOTM: begin
        mul_a = 33'(qa_r[k_r[1:0]]);
        mul_b = 33'(qb_r[k_r[1:0]]);
      end
      S_MPM: begin
        case (k_r)
          4'd0:    begin mul_a = 33'(q_r[0]); mul_b = 33'(q_r[0]); end
          4'd1:    begin mul_a = 33'(q_r[1]); mul_b = 33'(q_r[1]); end
          4'd2:    begin mul_a = 33'(q_r[2]); mul_b = 33'(q_r[2]); end
          4'd3:    begin mul_a = 33'(q_r[0]); mul_b = 33'(q_r[1]); end
          4'd4:    begin mul_a = 33'(q_r[0]); mul_b = 33'(q_r[2]); end
          4'd5:    begin mul_a = 33'(q_r[1]); mul_b = 33'(q_r[2]); end
          4'd6:    begin mul_a = 33'(q_r[3]); mul_b = 33'(q_r[0]); end
          4'd7:    begin mul_a = 33'(q_r[3]); mul_b = 33'(q_r[1]); end
          default: begin mul_a = 33'(q_r[3]); mul_b = 33'(q_r[2]); end
        endcase
      end
      S_MEM: begin
        mul_a = 33'(rm_r[k_r]);
        mul_b = 33'(s_r[col_of(k_r)]);
      end
      default: ;
    endcase
  end

  assign busy       = state_r != S_IDLE;
  assign out_strobe = (state_r == S_OUT) || (state_r == S_ACK);

  // Result transaction
  always_comb begin
    out_item        = '0;
    out_item.status = stat_r;
    if (state_r == S_ACK) begin
      out_item.last = 1'b1;
    end else begin
      out_item.row_index = row_r;
      out_item.last      = row_r == 2'd3;
      case (row_r)
        2'd0: begin
          out_item.col0 = m_r[0]; out_item.col1 = m_r[1];
          out_item.col2 = m_r[2]; out_item.col3 = p_r[0];
        end
        2'd1: begin
          out_item.col0 = m_r[3]; out_item.col1 = m_r[4];
          out_item.col2 = m_r[5]; out_item.col3 = p_r[1];
        end
        2'd2: begin
          out_item.col0 = m_r[6]; out_item.col1 = m_r[7];
          out_item.col2 = m_r[8]; out_item.col3 = p_r[2];
        end
        default: out_item.col3 = $signed(ONE_Q16);
      endcase
    end
  end

  // Control state: sequencer, key counts, divider count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r[0]  <= '0;
      cnt_r[1]  <= '0;
      cnt_r[2]  <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && start) begin
        if (in_item.command == CMD_CLEAR) begin
          cnt_r[0] <= '0;
          cnt_r[1] <= '0;
          cnt_r[2] <= '0;
        end else if (wr_en) begin
          cnt_r[cmd_trk] <= cnt_r[cmd_trk] + CNT_W'(1);
        end
      end
      if (div_go)                div_cnt_r <= div_steps;
      else if (div_cnt_r != '0)  div_cnt_r <= div_cnt_r - 6'd1;
    end
  end

  // Divider: restoring, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (div_go) begin
      div_rem_r <= div_rem0;
      div_dq_r  <= div_dq0;
      div_den_r <= div_den;
    end else if (div_cnt_r != '0) begin
      if (div_rem2 >= {1'b0, div_den_r}) begin
        div_rem_r <= 32'(div_rem2 - {1'b0, div_den_r});
        div_dq_r  <= {div_dq_r[62:0], 1'b1};
      end else begin
        div_rem_r <= div_rem2[31:0];
        div_dq_r  <= {div_dq_r[62:0], 1'b0};
      end
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Datapath registers, advanced by sequencer state
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          t_r    <= in_item.time_value;
          trk_r  <= TRK_POS;
          stat_r <= (in_item.command <= CMD_ADD_SCL
                     && cnt_r[cmd_trk] == CNT_W'(MAX_KEYS)) ? STAT_FULL : STAT_OK;
        end
      end
      S_TRK: begin
        j_r <= IDX_W'(1);
        if (cur_n == '0) begin
          stat_r <= STAT_EMPTY;
          case (trk_r)
            TRK_POS: begin
              p_r[0] <= '0; p_r[1] <= '0; p_r[2] <= '0;
            end
            TRK_ROT: begin
              q_r[0] <= '0; q_r[1] <= '0; q_r[2] <= '0; q_r[3] <= QONE;
            end
            default: begin
              s_r[0] <= $signed(ONE_Q16);
              s_r[1] <= $signed(ONE_Q16);
              s_r[2] <= $signed(ONE_Q16);
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_hit) b_r <= rd_r;
        else          j_r <= j_r + IDX_W'(1);
      end
      S_HOLD: begin
        k_r <= 4'd0;
        case (trk_r)
          TRK_POS: begin
            p_r[0] <= vcomp(rd_r, 2'd0);
            p_r[1] <= vcomp(rd_r, 2'd1);
            p_r[2] <= vcomp(rd_r, 2'd2);
          end
          TRK_ROT: begin
            for (int i = 0; i < 4; i++) qin_r[i] <= qcomp(rd_r, 2'(i));
            ret_r <= S_QSET;
          end
          default: begin
            s_r[0] <= vcomp(rd_r, 2'd0);
            s_r[1] <= vcomp(rd_r, 2'd1);
            s_r[2] <= vcomp(rd_r, 2'd2);
          end
        endcase
      end
      S_SEGA: begin
        a_r <= rd_r;
        u_r <= 16'd0;
      end
      S_UDIV: if (div_cnt_r == '0) u_r <= div_dq_r[15:0];
      S_UGO:  k_r <= 4'd0;
      S_LADD: begin
        if (trk_r == TRK_POS) p_r[k_r[1:0]] <= lerp_val;
        else                  s_r[k_r[1:0]] <= lerp_val;
        k_r <= k_r + 4'd1;
      end
      S_RA: begin
        for (int i = 0; i < 4; i++) qin_r[i] <= qcomp(a_r, 2'(i));
        ret_r <= S_RB;
        k_r   <= 4'd0;
      end
      S_RB: begin
        for (int i = 0; i < 4; i++) begin
          qa_r[i]  <= nq_r[i];
          qin_r[i] <= qcomp(b_r, 2'(i));
        end
        ret_r <= S_RBD;
        k_r   <= 4'd0;
      end
      S_RBD: begin
        for (int i = 0; i < 4; i++) qb_r[i] <= nq_r[i];
        dot_r <= '0;
        k_r   <= 4'd0;
      end
      S_DOTA: begin
        dot_r <= dot_r + prod_r[63:0];
        k_r   <= k_r + 4'd1;
      end
      S_FLIP: begin
        if (dot_r < 0) begin
          for (int i = 0; i < 4; i++) qb_r[i] <= -qb_r[i];
        end
        bit_r <= 4'd15;
      end
      S_MID: begin
        for (int i = 0; i < 4; i++) qin_r[i] <= Q_W'(qa_r[i]) + Q_W'(qb_r[i]);
        ret_r <= S_MIDD;
        k_r   <= 4'd0;
      end
      S_MIDD: begin
        for (int i = 0; i < 4; i++) begin
          if (u_r[bit_r]) qa_r[i] <= nq_r[i];
          else            qb_r[i] <= nq_r[i];
        end
        bit_r <= bit_r - 4'd1;
      end
      S_RFIN: begin
        for (int i = 0; i < 4; i++) qin_r[i] <= Q_W'(qa_r[i]);
        ret_r <= S_QSET;
        k_r   <= 4'd0;
      end
      S_QSET: begin
        for (int i = 0; i < 4; i++) q_r[i] <= nq_r[i];
      end
      S_NSQA: begin
        n2_r <= ((k_r == 4'd0) ? 64'd0 : n2_r) + prod_r[63:0];
        if (k_r == 4'd3) begin
          rx_r   <= n2_r + prod_r[63:0];
          rr_r   <= 64'd0;
          rbit_r <= 64'd1 << 62;
          k_r    <= 4'd0;
        end else begin
          k_r <= k_r + 4'd1;
        end
      end
      S_NROOT: begin
        if ({1'b0, rx_r} >= root_try) begin
          rx_r <= rx_r - root_try[63:0];
          rr_r <= (rr_r >> 1) + rbit_r;
        end else begin
          rr_r <= rr_r >> 1;
        end
        rbit_r <= rbit_r >> 2;
      end
      S_NDIVS: begin
        if (k_r == 4'd0 && rr_r == 64'd0) begin
          nq_r[0] <= '0; nq_r[1] <= '0; nq_r[2] <= '0; nq_r[3] <= QONE;
        end
      end
      S_NDIVW: begin
        if (div_cnt_r == '0) begin
          nq_r[k_r[1:0]] <= qin_cur[Q_W-1] ? -$signed(div_dq_r[QN_W-1:0])
                                           : $signed(div_dq_r[QN_W-1:0]);
          k_r <= k_r + 4'd1;
        end
      end
      S_NEXT: begin
        trk_r <= trk_r + 2'd1;
        k_r   <= 4'd0;
      end
      S_MPA: begin
        pp_r[k_r] <= prod_r[59:0];
        k_r       <= (k_r == 4'd8) ? 4'd0 : k_r + 4'd1;
      end
      S_MR: begin
        rm_r[0] <= rq((62'sd1 <<< 56) - 62'sd2 * (62'(pp_r[1]) + 62'(pp_r[2])));
        rm_r[1] <= rq(62'sd2 * (62'(pp_r[3]) - 62'(pp_r[8])));
        rm_r[2] <= rq(62'sd2 * (62'(pp_r[4]) + 62'(pp_r[7])));
        rm_r[3] <= rq(62'sd2 * (62'(pp_r[3]) + 62'(pp_r[8])));
        rm_r[4] <= rq((62'sd1 <<< 56) - 62'sd2 * (62'(pp_r[0]) + 62'(pp_r[2])));
        rm_r[5] <= rq(62'sd2 * (62'(pp_r[5]) - 62'(pp_r[6])));
        rm_r[6] <= rq(62'sd2 * (62'(pp_r[4]) - 62'(pp_r[7])));
        rm_r[7] <= rq(62'sd2 * (62'(pp_r[5]) + 62'(pp_r[6])));
        rm_r[8] <= rq((62'sd1 <<< 56) - 62'sd2 * (62'(pp_r[0]) + 62'(pp_r[1])));
        k_r     <= 4'd0;
      end
      S_MEA: begin
        m_r[k_r] <= sat32(elem_full);
        k_r      <= k_r + 4'd1;
        row_r    <= 2'd0;
      end
      S_OUT: row_r <= row_r + 2'd1;
      default: ;
    endcase
  end

endmodule

/* design/kti_checker.sv */
// Port-level checker for the keyframe TRS interpolator, bound to the top level.
// Depends on kti_pkg and keyframe_trs_interpolator_macros.svh.
`timescale 1ns / 1ps
`include "keyframe_trs_interpolator_macros.svh"

module kti_checker
  import kti_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input kti_in_t  in_item,
  input logic     out_strobe,
  input kti_out_t out_item
);

  // a result only comes out of a transaction in flight
  `KTI_ASSERT_SAME(a_strobe_busy, out_strobe, busy, "result outside a transaction")

  // the final row closes the transaction
  `KTI_ASSERT_NEXT(a_last_ends, out_strobe && out_item.last, !out_strobe, "result after last")

  // rows of a matrix follow back to back in order
  `KTI_ASSERT_NEXT(a_row_order, out_strobe && !out_item.last,
                   out_strobe && out_item.row_index == $past(out_item.row_index) + 2'd1,
                   "matrix rows out of order")

  // row three is always the final result
  `KTI_ASSERT_SAME(a_row3_last, out_strobe && out_item.row_index == 2'd3,
                   out_item.last, "row three not marked last")

  // an accepted evaluate keeps the block busy
  `KTI_ASSERT_NEXT(a_eval_busy, start && !busy && in_item.command == CMD_EVAL, busy,
                   "evaluate not taken up")

endmodule

bind keyframe_trs_interpolator kti_checker u_kti_checker (.*);
